// File: rtl/hpv_pkg.sv
package hpv_pkg;

  // Byte counter width; it must cover header plus body.
  localparam int COUNT_BITS = 25;
  localparam int LEN_BITS = 25;
  localparam int NEED_BITS = ((COUNT_BITS > 26) ? COUNT_BITS : 26) + 1;
  localparam logic [LEN_BITS-1:0] LEN_SAT = '1;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 24;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEADER_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BODY_LIMIT = 2'd1;
  localparam logic [15:0] HEADER_LIMIT_RESET = 16'd8192;
  localparam logic [23:0] BODY_LIMIT_RESET = 24'd1048576;

  // Verdict codes.
  localparam logic [1:0] V_INCOMPLETE = 2'd0;
  localparam logic [1:0] V_READY = 2'd1;
  localparam logic [1:0] V_INVALID = 2'd2;

  // Content-length value stages.
  localparam logic [1:0] CL_NONE = 2'd0;
  localparam logic [1:0] CL_DIGITS = 2'd1;
  localparam logic [1:0] CL_TRAIL = 2'd2;
  localparam logic [1:0] CL_BAD = 2'd3;

  // Patterns, right aligned in a fixed-width vector.
  localparam int PAT_BYTES = 18;
  localparam logic [8*PAT_BYTES-1:0] REQ_ROOT = "POST / HTTP/1.1";
  localparam logic [8*PAT_BYTES-1:0] REQ_RPC = "POST /rpc HTTP/1.1";
  localparam logic [8*PAT_BYTES-1:0] NAME_CL = "content-length";
  localparam logic [8*PAT_BYTES-1:0] NAME_AUTH = "authorization";
  localparam logic [8*PAT_BYTES-1:0] NAME_TE = "transfer-encoding";
  localparam logic [4:0] REQ_ROOT_LEN = 5'd15;
  localparam logic [4:0] REQ_RPC_LEN = 5'd18;
  localparam logic [4:0] NAME_CL_LEN = 5'd14;
  localparam logic [4:0] NAME_AUTH_LEN = 5'd13;
  localparam logic [4:0] NAME_TE_LEN = 5'd17;

  typedef enum logic [5:0] {
    PH_REQ       = 6'b000001,
    PH_NAME      = 6'b000010,
    PH_VAL_CL    = 6'b000100,
    PH_VAL_AUTH  = 6'b001000,
    PH_VAL_OTHER = 6'b010000,
    PH_BODY      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [15:0] body_start;
    logic [23:0] body_length;
    logic        has_auth;
    logic [15:0] auth_offset;
    logic [15:0] auth_length;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] byte_count;
    phase_t                phase;
    logic [4:0]            pos;
    logic                  crlf;
    logic [2:0]            flags;
    logic                  header_error;
    logic                  length_seen;
    logic [LEN_BITS-1:0]   length_value;
    logic [1:0]            cl_stage;
    logic                  auth_seen;
    logic                  auth_nonspace;
    logic [15:0]           auth_start;
    logic [15:0]           auth_end;
    logic [15:0]           header_end_pos;
    logic [1:0]            latched;
  } parse_state_t;

endpackage

// File: rtl/hpv_in_stage.sv
module hpv_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hpv_pkg::in_item_t in_data,
  input  logic              take,
  output logic              hold_valid,
  output hpv_pkg::in_item_t hold_data
);

  // The holding register frees up in the same cycle its item moves on.
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

endmodule

// File: rtl/hpv_parser.sv
module hpv_parser (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [hpv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [hpv_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 take,
  input  hpv_pkg::in_item_t                    item,
  output hpv_pkg::out_item_t                   result
);

  logic [15:0] header_limit;
  logic [23:0] body_limit;
  hpv_pkg::parse_state_t st;
  hpv_pkg::parse_state_t st_next;

  // True when pattern text of length len holds character c at position pos.
  function automatic logic pat_hit(input logic [8*hpv_pkg::PAT_BYTES-1:0] text,
                                   input logic [4:0] len, input logic [4:0] pos,
                                   input logic [7:0] c);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < len) begin
      ch = text[8*(int'(len) - 1 - int'(pos)) +: 8];
    end
    return (pos < len) && (ch == c);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Apply one content byte to the parse state.
  function automatic hpv_pkg::parse_state_t feed(input hpv_pkg::parse_state_t s_in,
                                                 input logic [7:0] c_in,
                                                 input logic [15:0] idx);
    hpv_pkg::parse_state_t s;
    logic [7:0] c;
    logic [hpv_pkg::LEN_BITS+3:0] grown;
    s = s_in;
    c = c_in;
    grown = '0;
    case (s.phase)
      hpv_pkg::PH_REQ: begin
        if (!pat_hit(hpv_pkg::REQ_ROOT, hpv_pkg::REQ_ROOT_LEN, s.pos, c)) s.flags[0] = 1'b0;
        if (!pat_hit(hpv_pkg::REQ_RPC, hpv_pkg::REQ_RPC_LEN, s.pos, c)) s.flags[1] = 1'b0;
        if (s.pos != 5'd31) s.pos = s.pos + 5'd1;
      end
      hpv_pkg::PH_NAME: begin
        if (c == 8'h3A) begin
          if (s.pos == 5'd0) begin
            s.header_error = 1'b1;
            s.phase = hpv_pkg::PH_VAL_OTHER;
          end else if (s.flags[0] && s.pos == hpv_pkg::NAME_CL_LEN) begin
            if (s.length_seen) s.header_error = 1'b1;
            s.length_seen = 1'b1;
            s.length_value = '0;
            s.cl_stage = hpv_pkg::CL_NONE;
            s.phase = hpv_pkg::PH_VAL_CL;
          end else if (s.flags[1] && s.pos == hpv_pkg::NAME_AUTH_LEN) begin
            if (s.auth_seen) s.header_error = 1'b1;
            s.auth_seen = 1'b1;
            s.auth_nonspace = 1'b0;
            s.phase = hpv_pkg::PH_VAL_AUTH;
          end else begin
            if (s.flags[2] && s.pos == hpv_pkg::NAME_TE_LEN) s.header_error = 1'b1;
            s.phase = hpv_pkg::PH_VAL_OTHER;
          end
        end else begin
          // Header names match without regard to case.
          if (c >= 8'h41 && c <= 8'h5A) c = c + 8'd32;
          if (!pat_hit(hpv_pkg::NAME_CL, hpv_pkg::NAME_CL_LEN, s.pos, c)) s.flags[0] = 1'b0;
          if (!pat_hit(hpv_pkg::NAME_AUTH, hpv_pkg::NAME_AUTH_LEN, s.pos, c)) s.flags[1] = 1'b0;
          if (!pat_hit(hpv_pkg::NAME_TE, hpv_pkg::NAME_TE_LEN, s.pos, c)) s.flags[2] = 1'b0;
          if (s.pos != 5'd31) s.pos = s.pos + 5'd1;
        end
      end
      hpv_pkg::PH_VAL_CL: begin
        if (is_ws(c)) begin
          if (s.cl_stage == hpv_pkg::CL_DIGITS) s.cl_stage = hpv_pkg::CL_TRAIL;
        end else if (c >= 8'h30 && c <= 8'h39 && s.cl_stage <= hpv_pkg::CL_DIGITS) begin
          s.cl_stage = hpv_pkg::CL_DIGITS;
          // Times ten as two shifts, then the digit; saturate on overflow.
          grown = {1'b0, s.length_value, 3'b000} + {3'b000, s.length_value, 1'b0}
                  + {{(hpv_pkg::LEN_BITS){1'b0}}, c[3:0]};
          if (grown > {4'b0000, hpv_pkg::LEN_SAT}) s.length_value = hpv_pkg::LEN_SAT;
          else s.length_value = grown[hpv_pkg::LEN_BITS-1:0];
        end else begin
          s.cl_stage = hpv_pkg::CL_BAD;
        end
      end
      hpv_pkg::PH_VAL_AUTH: begin
        if (!is_ws(c)) begin
          if (!s.auth_nonspace) s.auth_start = idx;
          s.auth_nonspace = 1'b1;
          s.auth_end = idx + 16'd1;
        end
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // Close a line that is not the end of the header.
  function automatic hpv_pkg::parse_state_t end_line(input hpv_pkg::parse_state_t s_in,
                                                     input logic [15:0] term,
                                                     input logic [23:0] blimit);
    hpv_pkg::parse_state_t s;
    s = s_in;
    case (s.phase)
      hpv_pkg::PH_REQ: begin
        if (!(s.flags[0] && s.pos == hpv_pkg::REQ_ROOT_LEN) &&
            !(s.flags[1] && s.pos == hpv_pkg::REQ_RPC_LEN)) s.header_error = 1'b1;
      end
      hpv_pkg::PH_NAME: begin
        s.header_error = 1'b1;
      end
      hpv_pkg::PH_VAL_CL: begin
        if ((s.cl_stage != hpv_pkg::CL_DIGITS && s.cl_stage != hpv_pkg::CL_TRAIL) ||
            s.length_value > {1'b0, blimit}) s.header_error = 1'b1;
      end
      hpv_pkg::PH_VAL_AUTH: begin
        if (!s.auth_nonspace) begin
          s.auth_start = term;
          s.auth_end = term;
        end
      end
      default: begin
      end
    endcase
    s.phase = hpv_pkg::PH_NAME;
    s.pos = 5'd0;
    s.flags = 3'b111;
    return s;
  endfunction

  function automatic logic [1:0] body_verdict(input hpv_pkg::parse_state_t s);
    logic [hpv_pkg::NEED_BITS-1:0] need;
    logic [hpv_pkg::NEED_BITS-1:0] have;
    need = hpv_pkg::NEED_BITS'(s.header_end_pos) + hpv_pkg::NEED_BITS'(s.length_value);
    have = hpv_pkg::NEED_BITS'(s.byte_count);
    if (have < need) return hpv_pkg::V_INCOMPLETE;
    if (have == need) return hpv_pkg::V_READY;
    return hpv_pkg::V_INVALID;
  endfunction

  function automatic hpv_pkg::parse_state_t cleared();
    hpv_pkg::parse_state_t s;
    s = '0;
    s.phase = hpv_pkg::PH_REQ;
    s.flags = 3'b111;
    s.latched = hpv_pkg::V_INCOMPLETE;
    return s;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= hpv_pkg::HEADER_LIMIT_RESET;
      body_limit <= hpv_pkg::BODY_LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == hpv_pkg::CFG_HEADER_LIMIT) header_limit <= cfg_data[15:0];
      if (cfg_index == hpv_pkg::CFG_BODY_LIMIT) body_limit <= cfg_data[23:0];
    end
  end

  // One byte of parse work: next state and the result for this byte.
  always_comb begin
    logic [1:0] v;
    logic [7:0] b;
    logic [15:0] i16;
    logic done;
    logic skip;
    st_next = st;
    v = hpv_pkg::V_INCOMPLETE;
    b = item.data_byte;
    i16 = st.byte_count[15:0];
    done = 1'b0;
    skip = 1'b0;
    result = '0;
    if (item.action) begin
      st_next = cleared();
    end else begin
      if (st.byte_count != '1) begin
        st_next.byte_count = st.byte_count + hpv_pkg::COUNT_BITS'(1);
      end
      if (st.latched == hpv_pkg::V_INVALID) begin
        v = hpv_pkg::V_INVALID;
      end else if (st.phase == hpv_pkg::PH_BODY) begin
        v = body_verdict(st_next);
      end else if (st_next.byte_count > hpv_pkg::COUNT_BITS'(header_limit)) begin
        v = hpv_pkg::V_INVALID;
      end else begin
        // A held CR is either a line end or plain content.
        if (st_next.crlf) begin
          st_next.crlf = 1'b0;
          if (b == 8'h0A) begin
            done = (st_next.phase == hpv_pkg::PH_NAME) && (st_next.pos == 5'd0);
            if (!done) begin
              st_next = end_line(st_next, i16 - 16'd1, body_limit);
              skip = 1'b1;
            end
          end else begin
            st_next = feed(st_next, 8'h0D, i16 - 16'd1);
          end
        end
        if (!skip) begin
          if (!done) begin
            if (b == 8'h0D) st_next.crlf = 1'b1;
            else st_next = feed(st_next, b, i16);
          end else if (st_next.header_error || !st_next.length_seen) begin
            v = hpv_pkg::V_INVALID;
          end else begin
            st_next.phase = hpv_pkg::PH_BODY;
            st_next.header_end_pos = st_next.byte_count[15:0];
            v = body_verdict(st_next);
          end
        end
      end
      st_next.latched = v;
      result.verdict = v;
      if (v == hpv_pkg::V_READY) begin
        result.body_start = st_next.header_end_pos;
        result.body_length = st_next.length_value[23:0];
        result.has_auth = st_next.auth_seen;
        if (st_next.auth_seen) begin
          result.auth_offset = st_next.auth_start;
          result.auth_length = st_next.auth_end - st_next.auth_start;
        end
      end
    end
  end

  // Parse state advances once per transfer out of the holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cleared();
    end else if (take) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/hpv_out_stage.sv
module hpv_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hpv_pkg::out_item_t result,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               can_load,
  output hpv_pkg::out_item_t out_data
);

  // The result register takes a new value when empty or being drained.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= result;
    end
  end

endmodule

// File: rtl/http_post_request_validator_core.sv
// POST request header checker, one request byte per transfer.
// Input channel (in_valid/in_ready/in_data): action 1 clears the parse state,
// action 0 appends data_byte. Every input transfer yields exactly one result
// on the output channel (out_valid/out_ready/out_data): the verdict on all
// bytes so far (incomplete, ready, invalid) with body and authorization
// offsets and lengths when ready.
// An item waits in the input holding register; its result is computed by
// the parse update and captured in the result register, from which it can
// transfer out. Throughput is one byte per cycle while the receiver does not
// stall, set by the combinational parse update between the two registers.
// When the receiver stalls, the result register holds its item and the input
// holding register fills; in_ready then drops until out_ready returns.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// index 0 is the header size limit, index 1 the body length limit, others
// are ignored. Reset empties both registers, clears the parse state and
// restores the limits to 8192 and 1048576.
module http_post_request_validator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  hpv_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hpv_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [hpv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hpv_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  logic               take;
  logic               hold_valid;
  hpv_pkg::in_item_t  hold_data;
  hpv_pkg::out_item_t result;
  logic               can_load;

  // An item moves on when the result register can accept it.
  assign take = hold_valid && can_load;

  hpv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  hpv_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .item      (hold_data),
    .result    (result)
  );

  hpv_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .can_load  (can_load),
    .out_data  (out_data)
  );

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // Offsets and lengths are reported only with a ready verdict.
  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.verdict != hpv_pkg::V_READY) |->
      (out_data.body_start == 16'd0 && out_data.body_length == 24'd0 &&
       !out_data.has_auth))
    else $error("fields set without ready verdict");

  // No authorization means no authorization span.
  a_auth_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.has_auth) |->
      (out_data.auth_offset == 16'd0 && out_data.auth_length == 16'd0))
    else $error("authorization span without header");

  // A transfer into the result register always comes from a held item.
  a_take_held: assert property (@(posedge clk) disable iff (rst)
    take |-> hold_valid && (!out_valid || out_ready))
    else $error("item moved without space");

endmodule
